FILE: rtl/core/pqe_pkg.sv
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types and constants of the polyline quad expander: register map,
// field widths, saturation limits, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pqe_pkg;

    // Configuration field widths and register map.
    localparam int LW_W    = 8;
    localparam int FR_W    = 14;
    localparam int H_W     = 13;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 8'd1;
    localparam logic [FR_W-1:0] FRAME_WIDTH_RST  = 14'd640;
    localparam logic [FR_W-1:0] FRAME_HEIGHT_RST = 14'd480;

    // Result format and divider sizes.
    localparam int OUT_W    = 18;
    localparam int N_CORNER = 8;
    localparam int OFFQ_W   = 25;
    localparam int NQ_W     = 18;
    localparam int NDEN_W   = 15;

    localparam logic signed [OUT_W-1:0] Q_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] Q_MIN = -18'sd131072;
    localparam logic [NQ_W-1:0] MAG_MAX_POS = 18'd131071;
    localparam logic [NQ_W-1:0] MAG_MAX_NEG = 18'd131072;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQRT,
        S_ODIV_GO,
        S_ODIV,
        S_PREP,
        S_NDIV_GO,
        S_NDIV,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic sq_load;
        logic sq_step;
        logic odiv_start;
        logic prep;
        logic ndiv_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seg_req;
        logic sq_last;
        logic odiv_done;
        logic ndiv_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/pqe_div.sv
// ----------------------------------------------------------------------------
// pqe_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QW bits unless o_ovf is set, so only QW steps are run.
// ----------------------------------------------------------------------------
module pqe_div #(
    parameter int NW = 32,
    parameter int DW = 15,
    parameter int QW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic          o_done
);
    localparam int XW = (NW > DW) ? NW : DW;
    localparam int CW = $clog2(QW);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic          r_ovf;
    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;

    logic [XW-1:0] hi_x;
    logic [XW-1:0] den_x;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign hi_x  = XW'(i_num >> QW);
    assign den_x = XW'(i_den);
    assign trial = {r_rem, r_q[QW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The low numerator bits shift out of the top of r_q while quotient bits
    // shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= hi_x[DW-1:0];
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
            r_ovf <= hi_x >= den_x;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;
    assign o_done = r_done;

endmodule

FILE: rtl/core/pqe_ctrl.sv
// ----------------------------------------------------------------------------
// pqe_ctrl
// Sequencer of the quad expander: accepts a point and, when it closes a
// segment, walks the datapath through square root, offset division, corner
// setup, normalization and result load.
// ----------------------------------------------------------------------------
module pqe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  pqe_pkg::t_sts i_sts,
    output pqe_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import pqe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.seg_req) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:      n_state = S_SQRT;
            S_SQRT: begin
                if (i_sts.sq_last) begin
                    n_state = S_ODIV_GO;
                end
            end
            S_ODIV_GO: n_state = S_ODIV;
            S_ODIV: begin
                if (i_sts.odiv_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:    n_state = S_NDIV_GO;
            S_NDIV_GO: n_state = S_NDIV;
            S_NDIV: begin
                if (i_sts.ndiv_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_SQ:      o_cmd.sq_load    = 1'b1;
            S_SQRT:    o_cmd.sq_step    = 1'b1;
            S_ODIV_GO: o_cmd.odiv_start = 1'b1;
            S_ODIV:    o_cmd            = '0;
            S_PREP:    o_cmd.prep       = 1'b1;
            S_NDIV_GO: o_cmd.ndiv_start = 1'b1;
            S_NDIV:    o_cmd            = '0;
            S_LOAD:    o_cmd.out_load   = i_sts.out_free;
            default:   o_cmd            = '0;
        endcase
    end

endmodule

FILE: rtl/core/pqe_dp.sv
// ----------------------------------------------------------------------------
// pqe_dp
// Datapath of the quad expander: previous point, segment deltas, bit-serial
// square root, two offset dividers, eight normalizing dividers with
// saturation, and the result register.
// ----------------------------------------------------------------------------
module pqe_dp #(
    parameter int COORD_BITS = 13
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  pqe_pkg::t_cmd                           i_cmd,
    output pqe_pkg::t_sts                           o_sts,
    input  logic [COORD_BITS-1:0]                   i_point_x,
    input  logic [COORD_BITS-1:0]                   i_point_y,
    input  logic                                    i_first_point,
    input  logic [pqe_pkg::LW_W-1:0]                i_line_width,
    input  logic [pqe_pkg::FR_W-1:0]                i_frame_width,
    input  logic [pqe_pkg::FR_W-1:0]                i_frame_height,
    input  logic                                    i_out_stall,
    output logic                                    o_out_valid,
    output logic [pqe_pkg::N_CORNER-1:0][pqe_pkg::OUT_W-1:0] o_corner,
    output logic                                    o_degenerate
);
    import pqe_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int SW   = 2 * C + 1;
    localparam int SQW  = C + 16;
    localparam int RW   = 2 * SQW;
    localparam int SCW  = $clog2(SQW);
    localparam int PW   = LW_W + C;
    localparam int ONW  = PW + 32;
    localparam int MW   = (C > H_W) ? C : H_W;
    localparam int DFW  = MW + 18;
    localparam int NNW  = DFW + 1;

    // Point history and segment registers.
    logic [C-1:0] r_prev_x;
    logic [C-1:0] r_prev_y;
    logic         r_have_prev;
    logic [C-1:0] r_x0;
    logic [C-1:0] r_y0;
    logic [C-1:0] r_x1;
    logic [C-1:0] r_y1;
    logic [C-1:0] r_adx;
    logic [C-1:0] r_ady;
    logic         r_sx;
    logic         r_sy;
    logic         r_degen;
    logic [PW-1:0] r_prod_x;
    logic [PW-1:0] r_prod_y;

    // Square root unit.
    logic [RW-1:0]    r_rad;
    logic [SQW-1:0]   r_root;
    logic [SQW+1:0]   r_rem;
    logic [SCW-1:0]   r_sq_cnt;

    logic             r_out_valid;
    logic             r_out_degen;

    logic [C:0]       dxw;
    logic [C:0]       dyw;
    logic [C:0]       dxn;
    logic [C:0]       dyn;
    logic [2*C-1:0]   sqx;
    logic [2*C-1:0]   sqy;
    logic [SW-1:0]    ssum;
    logic [PW-1:0]    prod_x;
    logic [PW-1:0]    prod_y;
    logic [SQW+3:0]   rt;
    logic [SQW+3:0]   tr;
    logic [SQW+3:0]   rt_sub;
    logic             rt_ge;
    logic [ONW-1:0]   onum_x;
    logic [ONW-1:0]   onum_y;
    logic [OFFQ_W-1:0] oq_x;
    logic [OFFQ_W-1:0] oq_y;
    logic [OFFQ_W-1:0] ox_mag;
    logic [OFFQ_W-1:0] oy_mag;
    logic             odone_x;
    logic             odone_y;
    logic [H_W-1:0]   hx;
    logic [H_W-1:0]   hy;
    logic [N_CORNER-1:0] ndone;
    logic             out_free;

    assign dxw    = {1'b0, i_point_x} - {1'b0, r_prev_x};
    assign dyw    = {1'b0, i_point_y} - {1'b0, r_prev_y};
    assign dxn    = -dxw;
    assign dyn    = -dyw;
    assign sqx    = r_adx * r_adx;
    assign sqy    = r_ady * r_ady;
    assign ssum   = SW'(sqx) + SW'(sqy);
    assign prod_x = i_line_width * r_adx;
    assign prod_y = i_line_width * r_ady;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
        end else if (i_cmd.accept) begin
            r_prev_x    <= i_point_x;
            r_prev_y    <= i_point_y;
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x0  <= r_prev_x;
            r_y0  <= r_prev_y;
            r_x1  <= i_point_x;
            r_y1  <= i_point_y;
            r_sx  <= dxw[C];
            r_sy  <= dyw[C];
            r_adx <= dxw[C] ? dxn[C-1:0] : dxw[C-1:0];
            r_ady <= dyw[C] ? dyn[C-1:0] : dyw[C-1:0];
        end
        if (i_cmd.sq_load) begin
            r_degen  <= (ssum == '0);
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
        end
    end

    // Length in Q15: floor(sqrt(s * 2^30)), two radicand bits per step.
    assign rt     = {r_rem, r_rad[RW-1:RW-2]};
    assign tr     = {2'b00, r_root, 2'b01};
    assign rt_ge  = rt >= tr;
    assign rt_sub = rt - tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
        end else if (i_cmd.sq_load) begin
            r_sq_cnt <= '0;
        end else if (i_cmd.sq_step) begin
            r_sq_cnt <= r_sq_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_rad  <= RW'(ssum) << 30;
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad  <= r_rad << 2;
            r_root <= {r_root[SQW-2:0], rt_ge};
            r_rem  <= rt_ge ? rt_sub[SQW+1:0] : rt[SQW+1:0];
        end
    end

    // Offsets r*|delta|*2^31/dq, rounded to nearest; r*sin uses dy, r*cos dx.
    assign onum_x = (ONW'(r_prod_x) << 31) + ONW'(r_root >> 1);
    assign onum_y = (ONW'(r_prod_y) << 31) + ONW'(r_root >> 1);

    pqe_div #(
        .NW(ONW),
        .DW(SQW),
        .QW(OFFQ_W)
    ) u_odiv_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.odiv_start),
        .i_num  (onum_x),
        .i_den  (r_root),
        .o_quo  (oq_x),
        .o_ovf  (),
        .o_done (odone_x)
    );

    pqe_div #(
        .NW(ONW),
        .DW(SQW),
        .QW(OFFQ_W)
    ) u_odiv_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.odiv_start),
        .i_num  (onum_y),
        .i_den  (r_root),
        .o_quo  (oq_y),
        .o_ovf  (),
        .o_done (odone_y)
    );

    // A zero-length segment leaves the dividers with a zero divisor.
    assign ox_mag = r_degen ? '0 : oq_y;
    assign oy_mag = r_degen ? '0 : oq_x;

    assign hx = (i_frame_width[FR_W-1:1] == '0) ? H_W'(1) : i_frame_width[FR_W-1:1];
    assign hy = (i_frame_height[FR_W-1:1] == '0) ? H_W'(1) : i_frame_height[FR_W-1:1];

    // Corner order: start left, start right, end left, end right; x then y.
    // The normalized magnitude is floor((|v - h*2^16| + 2h) / 4h).
    for (genvar gk = 0; gk < N_CORNER; gk++) begin : g_corner
        localparam bit IS_Y   = (gk % 2) == 1;
        localparam bit IS_END = gk >= 4;
        localparam bit C_NEG  = ((gk % 4) == 0) || ((gk % 4) == 3);

        logic [C-1:0]           p;
        logic [H_W-1:0]         h;
        logic [OFFQ_W-1:0]      om;
        logic                   osub;
        logic signed [DFW-1:0]  base;
        logic signed [DFW-1:0]  offs;
        logic signed [DFW-1:0]  diff;
        logic signed [DFW-1:0]  diff_n;
        logic [DFW-1:0]         amag;
        logic [NNW-1:0]         nnum;
        logic [NNW-1:0]         r_nnum;
        logic                   r_neg;
        logic [NQ_W-1:0]        q;
        logic                   ovf;
        logic [OUT_W-1:0]       sat;
        logic [OUT_W-1:0]       r_out;

        assign p    = IS_END ? (IS_Y ? r_y1 : r_x1) : (IS_Y ? r_y0 : r_x0);
        assign h    = IS_Y ? hy : hx;
        assign om   = IS_Y ? oy_mag : ox_mag;
        assign osub = (IS_Y ? r_sx : r_sy) ^ C_NEG;

        assign base   = ($signed(DFW'(p)) - $signed(DFW'(h))) <<< 16;
        assign offs   = $signed(DFW'(om));
        assign diff   = osub ? (base - offs) : (base + offs);
        assign diff_n = -diff;
        assign amag   = diff[DFW-1] ? diff_n : diff;
        assign nnum   = NNW'(amag) + NNW'({h, 1'b0});

        always_ff @(posedge i_clk) begin
            if (i_cmd.prep) begin
                r_nnum <= nnum;
                r_neg  <= diff[DFW-1];
            end
        end

        pqe_div #(
            .NW(NNW),
            .DW(NDEN_W),
            .QW(NQ_W)
        ) u_ndiv (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(i_cmd.ndiv_start),
            .i_num  (r_nnum),
            .i_den  ({h, 2'b00}),
            .o_quo  (q),
            .o_ovf  (ovf),
            .o_done (ndone[gk])
        );

        always_comb begin
            if (r_neg) begin
                sat = (ovf || (q > MAG_MAX_NEG)) ? Q_MIN : OUT_W'(18'd0 - q);
            end else begin
                sat = (ovf || (q > MAG_MAX_POS)) ? Q_MAX : OUT_W'(q);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.out_load) begin
                r_out <= sat;
            end
        end

        assign o_corner[gk] = r_out;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_degen <= r_degen;
        end
    end

    assign o_sts.seg_req   = !i_first_point && r_have_prev;
    assign o_sts.sq_last   = r_sq_cnt == SCW'(SQW - 1);
    assign o_sts.odiv_done = odone_x && odone_y;
    assign o_sts.ndiv_done = &ndone;
    assign o_sts.out_free  = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_degenerate = r_out_degen;

endmodule

FILE: rtl/core/polyline_quad_expander_top.sv
// ----------------------------------------------------------------------------
// polyline_quad_expander_top
// Expands each segment of a polyline into the four corners of a thick-line
// quad, normalized to the frame and given in signed Q3.14.
//
// Points enter on the input channel (i_in_valid / o_in_stall), one per beat.
// A beat with i_first_point set, or the first beat after reset, only stores
// the point and frees the input in the next cycle. Any other point closes a
// segment: the input stays stalled while the bit-serial square root
// (COORD_BITS + 16 steps), the 25-step offset dividers and the 18-step
// normalizing dividers run. The result then sits in an output register
// with o_out_valid high until a beat with i_out_stall low takes it; the
// next point is accepted while it waits, and only the final load waits
// for the output register to drain. Reset clears the point history and
// the output valid and restores the registers to line width 1 and a 640
// by 480 frame. The user must write registers over the APB port only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module polyline_quad_expander_top #(
    parameter int COORD_BITS = 13
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pqe_pkg::PADDR_W-1:0]           paddr,
    input  logic [pqe_pkg::PDATA_W-1:0]           pwdata,
    output logic [pqe_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [COORD_BITS-1:0]                 i_point_x,
    input  logic [COORD_BITS-1:0]                 i_point_y,
    input  logic                                  i_first_point,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_start_left_x,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_start_left_y,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_start_right_x,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_start_right_y,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_end_left_x,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_end_left_y,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_end_right_x,
    output logic signed [pqe_pkg::OUT_W-1:0]      o_end_right_y,
    output logic                                  o_degenerate
);
    import pqe_pkg::*;

    logic [LW_W-1:0] r_line_width;
    logic [FR_W-1:0] r_frame_width;
    logic [FR_W-1:0] r_frame_height;
    logic            wr_en;
    logic [1:0]      reg_idx;
    t_cmd            cmd;
    t_sts            sts;
    logic [N_CORNER-1:0][OUT_W-1:0] corner;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LINE_WIDTH:   r_line_width   <= pwdata[LW_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FR_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_WIDTH:   prdata = PDATA_W'(r_line_width);
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    pqe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    pqe_dp #(
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_first_point (i_first_point),
        .i_line_width  (r_line_width),
        .i_frame_width (r_frame_width),
        .i_frame_height(r_frame_height),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_corner      (corner),
        .o_degenerate  (o_degenerate)
    );

    assign o_start_left_x  = $signed(corner[0]);
    assign o_start_left_y  = $signed(corner[1]);
    assign o_start_right_x = $signed(corner[2]);
    assign o_start_right_y = $signed(corner[3]);
    assign o_end_left_x    = $signed(corner[4]);
    assign o_end_left_y    = $signed(corner[5]);
    assign o_end_right_x   = $signed(corner[6]);
    assign o_end_right_y   = $signed(corner[7]);

endmodule

FILE: rtl/core/pqe_checker.sv
// ----------------------------------------------------------------------------
// pqe_checker
// Port-level checks of the quad expander, bound to the top level.
// ----------------------------------------------------------------------------
module pqe_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             i_first_point,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [pqe_pkg::OUT_W-1:0] o_start_left_x,
    input logic signed [pqe_pkg::OUT_W-1:0] o_start_left_y,
    input logic signed [pqe_pkg::OUT_W-1:0] o_start_right_x,
    input logic signed [pqe_pkg::OUT_W-1:0] o_start_right_y,
    input logic signed [pqe_pkg::OUT_W-1:0] o_end_left_x,
    input logic signed [pqe_pkg::OUT_W-1:0] o_end_left_y,
    input logic signed [pqe_pkg::OUT_W-1:0] o_end_right_x,
    input logic signed [pqe_pkg::OUT_W-1:0] o_end_right_y,
    input logic                             o_degenerate
);

    // A stalled result beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_start_left_x) && $stable(o_end_right_y)
            && $stable(o_degenerate))
        else $error("stalled result beat changed");

    // A point that opens a polyline is only stored, so the input frees at once.
    a_first_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_first_point |=> !o_in_stall)
        else $error("input stalled after a first point");

    // A zero-length segment collapses both corner pairs onto their endpoints.
    a_degen_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            o_start_left_x == o_start_right_x && o_start_left_y == o_start_right_y
            && o_end_left_x == o_end_right_x && o_end_left_y == o_end_right_y)
        else $error("degenerate result with distinct corners");

    // A result is only loaded at the end of segment work, with the input held.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while input was open");

endmodule

bind polyline_quad_expander_top pqe_checker u_pqe_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyline quad expander. Polyline points are
// queued by the stimulus process and sent by a clocked driver with random
// gaps. Every accepted point runs through a fixed-point model of the quad
// expansion, and each quad taken from the output is checked corner by corner.
// The register file is reprogrammed between phases, including degenerate
// frame sizes, a zero line width and a write to an unused address.
// ----------------------------------------------------------------------------
module tb;

    import pqe_pkg::*;

    localparam int COORD_BITS     = 13;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int TIMEOUT_CYCLES = 1500000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 3000;
    localparam int PHASE_POINTS   = 145;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  first;
    } t_point;

    typedef struct packed {
        logic [N_CORNER-1:0][OUT_W-1:0] corner;
        logic                           degenerate;
    } t_quad;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [COORD_BITS-1:0] i_point_x = '0;
    logic [COORD_BITS-1:0] i_point_y = '0;
    logic                  i_first_point = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [OUT_W-1:0] o_start_left_x, o_start_left_y;
    logic signed [OUT_W-1:0] o_start_right_x, o_start_right_y;
    logic signed [OUT_W-1:0] o_end_left_x, o_end_left_y;
    logic signed [OUT_W-1:0] o_end_right_x, o_end_right_y;
    logic                    o_degenerate;

    polyline_quad_expander_top #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_first_point  (i_first_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_start_left_x (o_start_left_x),
        .o_start_left_y (o_start_left_y),
        .o_start_right_x(o_start_right_x),
        .o_start_right_y(o_start_right_y),
        .o_end_left_x   (o_end_left_x),
        .o_end_left_y   (o_end_left_y),
        .o_end_right_x  (o_end_right_x),
        .o_end_right_y  (o_end_right_y),
        .o_degenerate   (o_degenerate)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench-side copy of the registers and the point history.
    longint unsigned cfg_line_width   = LINE_WIDTH_RST;
    longint unsigned cfg_frame_width  = FRAME_WIDTH_RST;
    longint unsigned cfg_frame_height = FRAME_HEIGHT_RST;
    logic [COORD_BITS-1:0] last_x = '0;
    logic [COORD_BITS-1:0] last_y = '0;
    logic                  have_last = 1'b0;

    t_point point_q[$];
    t_quad  quad_q[$];

    string corner_name [N_CORNER] = '{"start_left_x", "start_left_y", "start_right_x",
        "start_right_y", "end_left_x", "end_left_y", "end_right_x", "end_right_y"};

    int mismatches = 0;
    int points_queued = 0;
    int points_taken = 0;
    int quads_seen = 0;
    int settings_used = 1;
    bit idle_mode = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int send_gap = 0;
    int stall_gap = 0;
    int hold_left = 0;

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned rem, res, b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Normal offset r*delta/length in Q16, rounded half away from zero.
    function automatic longint signed normal_offset(input longint unsigned r,
                                                    input longint signed delta,
                                                    input longint unsigned len_q15);
        longint unsigned mag, num, q;
        longint signed qs;
        mag = (delta < 0) ? -delta : delta;
        num = (r * mag) << 31;
        q = (num + (len_q15 >> 1)) / len_q15;
        qs = q;
        return (delta < 0) ? -qs : qs;
    endfunction

    // Map a Q16 pixel coordinate to Q3.14 device coordinates, saturating.
    function automatic logic [OUT_W-1:0] to_ndc(input longint signed v,
                                                input longint unsigned half);
        longint unsigned h, mag, den, q;
        longint signed hs, diff, r;
        h = (half < 1) ? 1 : half;
        hs = h * 65536;
        diff = v - hs;
        mag = (diff < 0) ? -diff : diff;
        mag = mag << 14;
        den = h << 16;
        q = (mag + (den >> 1)) / den;
        if (q > 64'd131072)
            q = 64'd131072;
        r = q;
        if (diff < 0)
            r = -r;
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return r[OUT_W-1:0];
    endfunction

    function automatic void expand_point(input t_point p);
        longint signed x0, y0, x1, y1, dx, dy, ox, oy;
        longint unsigned s, hw, hh;
        t_quad q;
        if (p.first || !have_last) begin
            last_x = p.x;
            last_y = p.y;
            have_last = 1'b1;
            return;
        end
        x0 = last_x;
        y0 = last_y;
        x1 = p.x;
        y1 = p.y;
        dx = x1 - x0;
        dy = y1 - y0;
        s = dx * dx + dy * dy;
        ox = 0;
        oy = 0;
        if (s != 0) begin
            ox = normal_offset(cfg_line_width, dy, root64(s << 30));
            oy = normal_offset(cfg_line_width, dx, root64(s << 30));
        end
        hw = cfg_frame_width >> 1;
        hh = cfg_frame_height >> 1;
        q.corner[0] = to_ndc(x0 * 65536 - ox, hw);
        q.corner[1] = to_ndc(y0 * 65536 + oy, hh);
        q.corner[2] = to_ndc(x0 * 65536 + ox, hw);
        q.corner[3] = to_ndc(y0 * 65536 - oy, hh);
        q.corner[4] = to_ndc(x1 * 65536 - ox, hw);
        q.corner[5] = to_ndc(y1 * 65536 + oy, hh);
        q.corner[6] = to_ndc(x1 * 65536 + ox, hw);
        q.corner[7] = to_ndc(y1 * 65536 - oy, hh);
        q.degenerate = (s == 0);
        quad_q.push_back(q);
        last_x = p.x;
        last_y = p.y;
    endfunction

    // Mostly back-to-back beats, some short gaps, a few long ones; none outside idle_mode.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (!idle_mode || k < 55)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("quad %0d, %s: expected %0d, got %0d", quads_seen, field, want, got);
    endtask

    task automatic check_quad();
        t_quad got, want;
        int k;
        got.corner[0] = o_start_left_x;
        got.corner[1] = o_start_left_y;
        got.corner[2] = o_start_right_x;
        got.corner[3] = o_start_right_y;
        got.corner[4] = o_end_left_x;
        got.corner[5] = o_end_left_y;
        got.corner[6] = o_end_right_x;
        got.corner[7] = o_end_right_y;
        got.degenerate = o_degenerate;
        quads_seen++;
        if (quad_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("quad %0d arrived with no segment pending", quads_seen);
            return;
        end
        want = quad_q.pop_front();
        for (k = 0; k < N_CORNER; k++) begin
            if (got.corner[k] !== want.corner[k])
                report_mismatch(corner_name[k], $signed(want.corner[k]),
                                $signed(got.corner[k]));
        end
        if (got.degenerate !== want.degenerate)
            report_mismatch("degenerate", want.degenerate, got.degenerate);
    endtask

    // Point driver: the model is updated at the edge where a beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expand_point('{x: i_point_x, y: i_point_y, first: i_first_point});
                points_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (point_q.size() > 0) begin
                    t_point p;
                    p = point_q.pop_front();
                    i_point_x     <= p.x;
                    i_point_y     <= p.y;
                    i_first_point <= p.first;
                    i_in_valid    <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Quad monitor and output back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_quad();
            if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_gap > 0) begin
                stall_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_gap = pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINE_WIDTH:   cfg_line_width = val & 32'hFF;
            REG_FRAME_WIDTH:  cfg_frame_width = val & 32'h3FFF;
            REG_FRAME_HEIGHT: cfg_frame_height = val & 32'h3FFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(input int lw, input logic [PDATA_W-1:0] fw,
                            input logic [PDATA_W-1:0] fh);
        write_reg(REG_LINE_WIDTH, lw);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        settings_used++;
    endtask

    task automatic add_point(input int x, input int y, input bit first);
        t_point p;
        p.x = x[COORD_BITS-1:0];
        p.y = y[COORD_BITS-1:0];
        p.first = first;
        point_q.push_back(p);
        points_queued++;
    endtask

    // A polyline with random content; now and then it continues the previous
    // one, or carries a stray first-point flag in the middle.
    task automatic add_random_polyline();
        int n, k, x, y;
        n = $urandom_range(2, 12);
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
        add_point(x, y, $urandom_range(0, 9) != 0);
        for (k = 1; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    x = $urandom_range(0, COORD_MAX);
                    y = $urandom_range(0, COORD_MAX);
                end
                3, 4, 5: begin
                    x = x + $urandom_range(0, 16) - 8;
                    y = y + $urandom_range(0, 16) - 8;
                end
                6: ;
                7: begin
                    if ($urandom_range(0, 1))
                        x = $urandom_range(0, COORD_MAX);
                    else
                        y = $urandom_range(0, COORD_MAX);
                end
                8: begin
                    x = $urandom_range(0, 1) * COORD_MAX;
                    y = $urandom_range(0, 1) * COORD_MAX;
                end
                default: begin
                    x = x + $urandom_range(0, 600) - 300;
                    y = y + $urandom_range(0, 600) - 300;
                end
            endcase
            if (x < 0) x = 0;
            if (x > COORD_MAX) x = COORD_MAX;
            if (y < 0) y = 0;
            if (y > COORD_MAX) y = COORD_MAX;
            add_point(x, y, $urandom_range(0, 19) == 0);
        end
    endtask

    // Wait until every point is taken and every quad has come out, then give
    // a trailing first point time to finish before the registers change.
    task automatic drain();
        do @(negedge i_clk);
        while (point_q.size() != 0 || i_in_valid || quad_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int ph, base;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings; the opening point has no predecessor and no flag.
        add_point(100, 200, 0);
        add_point(300, 200, 0);
        add_point(300, 450, 0);
        add_point(300, 450, 0);
        add_point(0, 0, 1);
        add_point(COORD_MAX, COORD_MAX, 0);
        add_point(COORD_MAX, 0, 0);
        add_point(0, COORD_MAX, 0);
        add_point(0, 0, 0);
        add_point(320, 240, 0);
        add_point(320, 240, 1);
        add_point(321, 240, 0);
        add_point(321, 241, 0);
        add_point(13'h1555, 13'h0AAA, 0);
        add_point(13'h0AAA, 13'h1555, 0);
        add_point(0, 0, 1);
        add_point(COORD_MAX, COORD_MAX, 1);
        add_point(COORD_MAX - 1, COORD_MAX, 0);
        drain();

        for (ph = 1; ph <= 9; ph++) begin
            case (ph)
                1: set_regs(0, 16383, 1);
                2: begin
                    set_regs(255, 2, 0);
                    write_reg(REG_SPARE, 32'h0000_0007);
                end
                3: begin
                    set_regs(255, 32'hFFFF_2000, 8192);
                    hold_requests++;
                end
                default: begin
                    set_regs(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64)
                                                         : $urandom_range(2, 8192),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64)
                                                         : $urandom_range(2, 8192));
                end
            endcase
            idle_mode = (ph != 4);
            if (ph <= 3) begin
                add_point(0, 0, 1);
                add_point(COORD_MAX, COORD_MAX, 0);
                add_point(COORD_MAX, COORD_MAX, 0);
                add_point(0, COORD_MAX, 0);
                add_point(4096, 4096, 0);
            end
            base = points_queued;
            while (points_queued - base < PHASE_POINTS)
                add_random_polyline();
            drain();
        end

        $display("%0d points sent, %0d quads checked across %0d register settings",
                 points_taken, quads_seen, settings_used);
        $display("included zero width, tiny and oversized frames and a long output hold");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("timed out with %0d points queued and %0d quads pending",
                 point_q.size(), quad_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
